// ===== design/one_wire_bus_master_top_defines.svh =====
// Assertion macros for the one-wire bus master.
`ifndef ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define OWM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define OWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/owm_pkg.sv =====
// Shared types and constants of the one-wire bus master.
`default_nettype none
package owm_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int NUM_REGS    = 8;
   localparam int REG_IDX_W   = $clog2(NUM_REGS);
   localparam int CSR_IDX_W   = 8;

   // command codes on the func field
   localparam logic [1:0] FUNC_NONE  = 2'd0;
   localparam logic [1:0] FUNC_RESET = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   // delay register indexes
   localparam logic [REG_IDX_W-1:0] REG_RST_LOW   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_RST_WAIT  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_RST_TAIL  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WR_LOW    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_WR_HOLD   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_RD_LOW    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_RD_SAMPLE = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_RD_TAIL   = 3'd7;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef count_type [NUM_REGS-1:0] delay_array_type;

   localparam delay_array_type REG_DEFAULTS = '{
      count_type'(50), count_type'(5), count_type'(5), count_type'(50),
      count_type'(10), count_type'(500), count_type'(70), count_type'(500)};

   typedef struct packed {
      logic       bus_level;
      logic [7:0] tx_byte;
      logic [1:0] func;
   } req_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       presence;
      logic       done_res;
      logic       busy_res;
      logic       drive_low;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/owm_cfg.sv =====
// Delay register file written through the configuration channel.
`default_nettype none
module owm_cfg (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [owm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [15:0]                    csr_data,
   output owm_pkg::delay_array_type       delays
);
   import owm_pkg::*;

   delay_array_type regs_ff;

   assign csr_ready = 1'b1;
   assign delays    = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REG_DEFAULTS;
      end else if (csr_valid && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         regs_ff[csr_index[REG_IDX_W-1:0]] <= count_type'(csr_data);
      end
   end

endmodule
`default_nettype wire

// ===== design/owm_seq.sv =====
// Slot sequencer: phase, tick counter and bit shifter, one tick per beat.
`default_nettype none
module owm_seq (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       step,
   input  owm_pkg::req_type          req,
   input  owm_pkg::delay_array_type  delays,
   output owm_pkg::rsp_type          rsp
);
   import owm_pkg::*;

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RST_LOW  = 4'd1;
   localparam logic [3:0] PH_RST_WAIT = 4'd2;
   localparam logic [3:0] PH_RST_TAIL = 4'd3;
   localparam logic [3:0] PH_WR_LOW   = 4'd4;
   localparam logic [3:0] PH_WR_HOLD  = 4'd5;
   localparam logic [3:0] PH_RD_LOW   = 4'd6;
   localparam logic [3:0] PH_RD_WAIT  = 4'd7;
   localparam logic [3:0] PH_RD_TAIL  = 4'd8;
   localparam logic [3:0] PH_GAP      = 4'd9;

   logic [3:0]  phase_ff,    phase_in;
   count_type   count_ff,    count_in;
   logic [2:0]  bit_ff,      bit_in;
   logic [7:0]  shift_ff,    shift_in;
   logic [1:0]  op_ff,       op_in;
   logic        presence_ff, presence_in;
   logic [7:0]  rx_ff,       rx_in;

   logic [3:0]             ph;
   logic                   drive;
   logic                   done;
   count_type              raw_len;
   count_type              len;
   logic [COUNT_WIDTH:0]   count_inc;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      op_in       = op_ff;
      presence_in = presence_ff;
      rx_in       = rx_ff;
      done        = 1'b0;
      drive       = 1'b0;
      raw_len     = count_type'(1);

      // a command in idle starts on this very tick
      ph = phase_ff;
      if (phase_ff == PH_IDLE && req.func != FUNC_NONE) begin
         op_in    = req.func;
         count_in = '0;
         bit_in   = '0;
         shift_in = '0;
         unique case (req.func)
            FUNC_RESET: ph = PH_RST_LOW;
            FUNC_WRITE: begin
               ph       = PH_WR_LOW;
               shift_in = req.tx_byte;
            end
            default:    ph = PH_RD_LOW;
         endcase
      end

      unique case (ph)
         PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive = 1'b1;
         PH_WR_HOLD:                       drive = ~shift_in[0];
         default:                          drive = 1'b0;
      endcase

      // samples land on the first tick of a tail phase
      if (ph == PH_RST_TAIL && count_in == '0) begin
         presence_in = ~req.bus_level;
      end
      if (ph == PH_RD_TAIL && count_in == '0) begin
         shift_in = {req.bus_level, shift_in[7:1]};
      end

      unique case (ph)
         PH_RST_LOW:  raw_len = delays[REG_RST_LOW];
         PH_RST_WAIT: raw_len = delays[REG_RST_WAIT];
         PH_RST_TAIL: raw_len = delays[REG_RST_TAIL];
         PH_WR_LOW:   raw_len = delays[REG_WR_LOW];
         PH_WR_HOLD:  raw_len = delays[REG_WR_HOLD];
         PH_RD_LOW:   raw_len = delays[REG_RD_LOW];
         PH_RD_WAIT:  raw_len = delays[REG_RD_SAMPLE];
         PH_RD_TAIL:  raw_len = delays[REG_RD_TAIL];
         default:     raw_len = count_type'(1);
      endcase
      len       = (raw_len == '0) ? count_type'(1) : raw_len;
      count_inc = {1'b0, count_in} + (COUNT_WIDTH+1)'(1);

      phase_in = ph;
      if (ph != PH_IDLE) begin
         if (count_inc >= {1'b0, len}) begin
            count_in = '0;
            unique case (ph)
               PH_RST_LOW:  phase_in = PH_RST_WAIT;
               PH_RST_WAIT: phase_in = PH_RST_TAIL;
               PH_RST_TAIL: begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
               PH_WR_LOW:   phase_in = PH_WR_HOLD;
               PH_WR_HOLD:  begin
                  shift_in = {1'b0, shift_in[7:1]};
                  if (bit_in == 3'd7) begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_GAP;
                  end
               end
               PH_RD_LOW:   phase_in = PH_RD_WAIT;
               PH_RD_WAIT:  phase_in = PH_RD_TAIL;
               PH_RD_TAIL:  begin
                  if (bit_in == 3'd7) begin
                     rx_in    = shift_in;
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end else begin
                     phase_in = PH_GAP;
                  end
               end
               PH_GAP:      begin
                  bit_in   = bit_in + 3'd1;
                  phase_in = (op_in == FUNC_WRITE) ? PH_WR_LOW : PH_RD_LOW;
               end
               default:     phase_in = PH_IDLE;
            endcase
         end else begin
            count_in = count_inc[COUNT_WIDTH-1:0];
         end
      end

      rsp.drive_low = drive;
      rsp.busy_res  = (ph != PH_IDLE);
      rsp.done_res  = done;
      rsp.presence  = presence_in;
      rsp.rx_byte   = rx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         count_ff    <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         op_ff       <= FUNC_NONE;
         presence_ff <= 1'b0;
         rx_ff       <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         op_ff       <= op_in;
         presence_ff <= presence_in;
         rx_ff       <= rx_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/owm_out.sv =====
// Result register between the sequencer and the result channel.
`default_nettype none
module owm_out (
   input  wire                clock,
   input  wire                reset,
   input  wire                load,
   input  owm_pkg::rsp_type   rsp_in,
   output logic               can_load,
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output owm_pkg::rsp_type   rsp_out
);
   import owm_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   // a held result frees its slot on the beat that takes it
   assign can_load   = ~valid_ff | rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_out    = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/one_wire_bus_master_top.sv =====
// One-wire bus master: input tick stream in, per-tick bus control and status out.
//
// Every req beat is one tick of the bus timebase. It carries the sampled bus
// level and, while the master is idle, an optional command (reset with
// presence detect, write byte, read byte; bytes go LSB first). Each req beat
// yields exactly one rsp beat holding drive_low, busy, done, presence and the
// last received byte. A command given while busy is dropped.
// The rsp beat for a tick is valid in the cycle after its req beat.
// Throughput: one beat per cycle unless stalled; the sequencer's phase/counter
// update is the single stage between the req handshake and the result register.
// Stall: req_tready drops only while a result sits unread and rsp_tready is
// low; ticks then simply do not advance. Nothing is lost or repeated.
// Config: csr channel writes one 16-bit delay register per beat (index 0..7:
// reset low, presence wait, reset tail, write low, write hold, read low, read
// sample, read tail); other indexes are ignored. Always ready. Write only
// while idle. A zero delay counts as one tick.
// Reset (synchronous, active high): master idle, presence and rx byte
// cleared, delays back to 500/70/500/10/50/5/5/50, no result pending.
`default_nettype none
`include "one_wire_bus_master_top_defines.svh"
module one_wire_bus_master_top (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [15:0]                    req_tdata,   // func[1:0], tx_byte[9:2], bus_level[10]
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [15:0]                    rsp_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                                       // presence[3], rx_byte[11:4]
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [owm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [15:0]                    csr_data
);
   import owm_pkg::*;

   delay_array_type delays;
   req_type         req;
   rsp_type         rsp_next;
   rsp_type         rsp_hold;
   logic            can_load;
   logic            req_beat;

   assign req        = req_type'(req_tdata[10:0]);
   assign req_tready = can_load;
   assign req_beat   = req_tvalid & can_load;
   assign rsp_tdata  = {4'd0, rsp_hold};

   owm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .delays    (delays)
   );

   owm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (req_beat),
      .req    (req),
      .delays (delays),
      .rsp    (rsp_next)
   );

   owm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (req_beat),
      .rsp_in     (rsp_next),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_out    (rsp_hold)
   );

   // every accepted tick produces a result on the next cycle
   `OWM_ASSERT_NEXT(a_beat_gives_result, req_tvalid && req_tready, rsp_tvalid, "tick lost")
   // done and bus drive only ever appear while a command is in progress
   `OWM_ASSERT_NOW(a_done_busy, rsp_tvalid && rsp_hold.done_res, rsp_hold.busy_res, "done idle")
   `OWM_ASSERT_NOW(a_drive_busy, rsp_tvalid && rsp_hold.drive_low, rsp_hold.busy_res, "drive idle")

endmodule
`default_nettype wire

// ===== dv/one_wire_bus_master_top_tb.sv =====
// Self-checking testbench for the one-wire bus master: tick stream in, bus status out.
`timescale 1ns / 1ps
module one_wire_bus_master_top_tb;
   import owm_pkg::*;

   localparam int CLK_PERIOD  = 4;
   localparam int RESET_TICKS = 7;
   // The rsp beat comes in the cycle after its req beat; an idle tail at the end
   // lets any stray beat show up.
   localparam int TAIL_CYCLES = 8;
   // Slowest legal run: under 1.7k ticks (the power-on read and a long read left
   // running in the uneven set dominate), each waiting out the longest sender gap
   // plus the longest receiver stall; the limit leaves room several times over.
   localparam int CYCLE_LIMIT = 1_000_000;

   // Power-on delay values, index order as on the csr channel.
   localparam int DEFAULT_DELAY [NUM_REGS] = '{500, 70, 500, 10, 50, 5, 5, 50};

   localparam logic [1:0] START_CMD [3] = '{FUNC_RESET, FUNC_WRITE, FUNC_READ};
   localparam logic [1:0] ANY_FUNC  [4] = '{FUNC_NONE, FUNC_RESET, FUNC_WRITE, FUNC_READ};

   // Slot sequencer states of the predictor.
   typedef enum logic [3:0] {
      ST_IDLE, ST_RST_LOW, ST_RST_WAIT, ST_RST_TAIL, ST_WR_LOW, ST_WR_HOLD,
      ST_RD_LOW, ST_RD_WAIT, ST_RD_TAIL, ST_GAP
   } slot_state_type;

   // One row of the directed drill: a tick held for reps beats, optionally with
   // a status typed in by hand.
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] tx_byte;
      logic       bus_level;
      logic [7:0] reps;
      logic       typed;
      rsp_type    want;
   } drill_row_type;

   localparam rsp_type NO_STATUS = '0;

   // ---------------------------------------------------------------- DUT ports
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;   // func[1:0], tx_byte[9:2], bus_level[10]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b1;
   logic [15:0]          rsp_tdata;         // drive_low[0], busy_res[1], done_res[2],
                                            // presence[3], rx_byte[11:4]
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [15:0]          csr_data   = '0;

   one_wire_bus_master_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------ predictor state
   slot_state_type bus_state;
   int          slot_ticks;
   logic [2:0]  bit_num;
   logic [7:0]  shift_reg;
   logic [1:0]  active_cmd;
   logic        seen_presence;
   logic [7:0]  last_rx;
   count_type   delay_reg [NUM_REGS];

   rsp_type     pending_status [$];   // bus status still owed by the DUT, oldest first
   rsp_type     typed_status;         // hand-written status for the current drill row
   bit          use_typed = 1'b0;
   bit          quiet     = 1'b0;     // no idling on either side while set

   int          mismatches    = 0;
   int          ticks_sent    = 0;
   int          beats_checked = 0;
   int          cmd_starts [4] = '{0, 0, 0, 0};
   int          cycle_count   = 0;
   int          rsp_hold      = 0;
   int          rsp_gap;

   // Directed drill, run with every delay register at zero (one tick each):
   // reset with and without a slave answer, commands dropped while busy and on
   // the finishing tick, extreme bytes both ways, rx/presence retention.
   drill_row_type drill [14] = '{
      '{FUNC_NONE,  8'h00, 1'b1, 8'd1,  1'b1, rsp_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{FUNC_RESET, 8'h00, 1'b1, 8'd1,  1'b0, NO_STATUS},
      '{FUNC_RESET, 8'h00, 1'b1, 8'd1,  1'b0, NO_STATUS},   // dropped, busy
      '{FUNC_WRITE, 8'hFF, 1'b0, 8'd1,  1'b0, NO_STATUS},   // slave answers; dropped at done
      '{FUNC_NONE,  8'h00, 1'b1, 8'd1,  1'b1, rsp_type'{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
      '{FUNC_RESET, 8'h00, 1'b1, 8'd3,  1'b0, NO_STATUS},   // nobody answers
      '{FUNC_WRITE, 8'h00, 1'b1, 8'd1,  1'b0, NO_STATUS},
      '{FUNC_READ,  8'h00, 1'b0, 8'd22, 1'b0, NO_STATUS},   // reads ride over the write
      '{FUNC_WRITE, 8'hFF, 1'b1, 8'd23, 1'b0, NO_STATUS},
      '{FUNC_READ,  8'h00, 1'b0, 8'd31, 1'b0, NO_STATUS},   // all-zero byte
      '{FUNC_READ,  8'h00, 1'b1, 8'd31, 1'b0, NO_STATUS},   // all-one byte
      '{FUNC_NONE,  8'h00, 1'b1, 8'd1,  1'b1, rsp_type'{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{FUNC_RESET, 8'h00, 1'b0, 8'd3,  1'b0, NO_STATUS},   // rx byte must survive a reset
      '{FUNC_NONE,  8'h00, 1'b1, 8'd1,  1'b1, rsp_type'{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}}
   };

   // Ticks a slot state lasts; a zero register still counts one tick.
   function automatic int slot_len(input slot_state_type st);
      logic [REG_IDX_W-1:0] idx;
      case (st)
         ST_RST_LOW:  idx = REG_RST_LOW;
         ST_RST_WAIT: idx = REG_RST_WAIT;
         ST_RST_TAIL: idx = REG_RST_TAIL;
         ST_WR_LOW:   idx = REG_WR_LOW;
         ST_WR_HOLD:  idx = REG_WR_HOLD;
         ST_RD_LOW:   idx = REG_RD_LOW;
         ST_RD_WAIT:  idx = REG_RD_SAMPLE;
         ST_RD_TAIL:  idx = REG_RD_TAIL;
         default:     return 1;
      endcase
      return (delay_reg[idx] == '0) ? 1 : int'(delay_reg[idx]);
   endfunction

   // Advance the master by one tick and return the bus status of that tick.
   function automatic rsp_type advance_bus(input req_type r);
      rsp_type o;
      o = '0;
      // a command only lands while idle; it starts on this very tick
      if (bus_state == ST_IDLE && r.func != FUNC_NONE) begin
         active_cmd = r.func;
         slot_ticks = 0;
         bit_num    = '0;
         cmd_starts[r.func]++;
         case (r.func)
            FUNC_RESET: begin
               bus_state = ST_RST_LOW;
               shift_reg = '0;
            end
            FUNC_WRITE: begin
               bus_state = ST_WR_LOW;
               shift_reg = r.tx_byte;
            end
            default: begin
               bus_state = ST_RD_LOW;
               shift_reg = '0;
            end
         endcase
      end

      case (bus_state)
         ST_RST_LOW, ST_WR_LOW, ST_RD_LOW: o.drive_low = 1'b1;
         ST_WR_HOLD:                       o.drive_low = ~shift_reg[0];
         default:                          o.drive_low = 1'b0;
      endcase
      o.busy_res = (bus_state != ST_IDLE);

      // samples fall on the first tick of each tail
      if (bus_state == ST_RST_TAIL && slot_ticks == 0)
         seen_presence = ~r.bus_level;
      if (bus_state == ST_RD_TAIL && slot_ticks == 0)
         shift_reg = {r.bus_level, shift_reg[7:1]};

      if (bus_state != ST_IDLE) begin
         slot_ticks++;
         if (slot_ticks >= slot_len(bus_state)) begin
            slot_ticks = 0;
            case (bus_state)
               ST_RST_LOW:  bus_state = ST_RST_WAIT;
               ST_RST_WAIT: bus_state = ST_RST_TAIL;
               ST_RST_TAIL: begin
                  bus_state  = ST_IDLE;
                  o.done_res = 1'b1;
               end
               ST_WR_LOW:   bus_state = ST_WR_HOLD;
               ST_WR_HOLD: begin
                  shift_reg = shift_reg >> 1;
                  if (bit_num == 3'd7) begin
                     bus_state  = ST_IDLE;
                     o.done_res = 1'b1;
                  end else begin
                     bus_state = ST_GAP;
                  end
               end
               ST_RD_LOW:   bus_state = ST_RD_WAIT;
               ST_RD_WAIT:  bus_state = ST_RD_TAIL;
               ST_RD_TAIL: begin
                  if (bit_num == 3'd7) begin
                     last_rx    = shift_reg;
                     bus_state  = ST_IDLE;
                     o.done_res = 1'b1;
                  end else begin
                     bus_state = ST_GAP;
                  end
               end
               ST_GAP: begin
                  bit_num   = bit_num + 3'd1;
                  bus_state = (active_cmd == FUNC_WRITE) ? ST_WR_LOW : ST_RD_LOW;
               end
               default: bus_state = ST_IDLE;
            endcase
         end
      end

      o.presence = seen_presence;
      o.rx_byte  = last_rx;
      return o;
   endfunction

   task automatic compare_status(input rsp_type want, input rsp_type got);
      if (got.drive_low !== want.drive_low) begin
         $error("drive_low: expected %0b, got %0b", want.drive_low, got.drive_low);
         mismatches++;
      end
      if (got.busy_res !== want.busy_res) begin
         $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
         mismatches++;
      end
      if (got.done_res !== want.done_res) begin
         $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
         mismatches++;
      end
      if (got.presence !== want.presence) begin
         $error("presence: expected %0b, got %0b", want.presence, got.presence);
         mismatches++;
      end
      if (got.rx_byte !== want.rx_byte) begin
         $error("rx_byte: expected %02h, got %02h", want.rx_byte, got.rx_byte);
         mismatches++;
      end
   endtask

   // --------------------------------------------------------------- scoreboard
   // Everything is sampled at the rising edge. A req beat is predicted before
   // the rsp beat of the same edge is checked, so any latency is tolerated.
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      rsp_type got;
      if (reset) begin
         bus_state     = ST_IDLE;
         slot_ticks    = 0;
         bit_num       = '0;
         shift_reg     = '0;
         active_cmd    = FUNC_NONE;
         seen_presence = 1'b0;
         last_rx       = '0;
         foreach (delay_reg[i]) delay_reg[i] = count_type'(DEFAULT_DELAY[i]);
      end else begin
         // out-of-range indexes are dropped by the block
         if (csr_valid && csr_ready && csr_index < NUM_REGS)
            delay_reg[csr_index[REG_IDX_W-1:0]] = count_type'(csr_data);
         if (req_tvalid && req_tready) begin
            got = advance_bus(req_type'(req_tdata[$bits(req_type)-1:0]));
            pending_status.push_back(use_typed ? typed_status : got);
            ticks_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_status.size() == 0) begin
               $error("status beat %h arrived with nothing outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = pending_status.pop_front();
               compare_status(want, rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]));
               beats_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("watchdog expired with %0d status beats outstanding", pending_status.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------ idle pattern
   // Mostly back-to-back, often a short gap, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver back-pressure, changed on the falling edge only.
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
         rsp_hold   <= 0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else begin
         rsp_gap = pick_gap();
         rsp_tready <= (rsp_gap == 0);
         rsp_hold   <= (rsp_gap > 0) ? rsp_gap - 1 : 0;
      end
   end

   // ------------------------------------------------------------------ drivers
   // All driving happens on the falling edge. A tick leaves req_tvalid high on
   // return so the next one can follow back-to-back; park_req drops it.
   task automatic send_tick(input logic [1:0] f, input logic [7:0] tx, input logic lvl);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {5'b0, lvl, tx, f};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic park_req();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_random(input int lo, input int hi);
      for (int i = 0; i < NUM_REGS; i++)
         write_reg(CSR_IDX_W'(i), 16'($urandom_range(lo, hi)));
   endtask

   // Well-formed traffic: a command on most idle ticks, and only a sprinkle of
   // commands while busy (those must be dropped).
   task automatic random_ticks(input int n);
      logic [1:0] f;
      repeat (n) begin
         if (bus_state == ST_IDLE)
            f = ($urandom_range(0, 9) < 8) ? START_CMD[$urandom_range(0, 2)] : FUNC_NONE;
         else
            f = ($urandom_range(0, 9) == 0) ? ANY_FUNC[$urandom_range(0, 3)] : FUNC_NONE;
         send_tick(f, 8'($urandom), 1'($urandom));
      end
   endtask

   // Run the current command out with noise ticks, then hold off until every
   // status beat has been checked, leaving the block idle for csr writes.
   task automatic settle();
      while (bus_state != ST_IDLE)
         send_tick(ANY_FUNC[$urandom_range(0, 3)], 8'($urandom), 1'($urandom));
      park_req();
      while (pending_status.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      repeat (RESET_TICKS) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Drill with every delay at zero, the shortest legal slots.
      for (int i = 0; i < NUM_REGS; i++)
         write_reg(CSR_IDX_W'(i), 16'h0000);
      foreach (drill[k]) begin
         use_typed    = drill[k].typed;
         typed_status = drill[k].want;
         repeat (drill[k].reps)
            send_tick(drill[k].func, drill[k].tx_byte, drill[k].bus_level);
         use_typed = 1'b0;
      end
      settle();

      // Short slots; first stretch without any idling on either side.
      program_random(1, 4);
      quiet = 1'b1;
      random_ticks(50);
      quiet = 1'b0;
      random_ticks(50);
      settle();

      // Zeros mixed in, plus a write to an index the block must ignore.
      program_random(0, 3);
      write_reg(CSR_IDX_W'($urandom_range(NUM_REGS, 255)), 16'($urandom));
      random_ticks(80);
      settle();

      // Uneven, somewhat longer slots.
      program_random(1, 24);
      random_ticks(80);
      settle();

      // Power-on timing written back explicitly, then one full read byte.
      for (int i = 0; i < NUM_REGS; i++)
         write_reg(CSR_IDX_W'(i), 16'(DEFAULT_DELAY[i]));
      send_tick(FUNC_READ, 8'($urandom), 1'($urandom));
      settle();

      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d ticks, %0d status beats checked; commands started: reset %0d, write %0d, read %0d",
               ticks_sent, beats_checked, cmd_starts[FUNC_RESET], cmd_starts[FUNC_WRITE],
               cmd_starts[FUNC_READ]);
      $display("Delay sets: all zero, small random, uneven random and the power-on values");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
